>>> rtl/sweep_waveform_segment_plotter_assert.svh
// Assertion macros for the sweep waveform segment plotter checker
`ifndef SWEEP_WAVEFORM_SEGMENT_PLOTTER_ASSERT_SVH
`define SWEEP_WAVEFORM_SEGMENT_PLOTTER_ASSERT_SVH

// clocked check, off while reset is asserted
`define SWSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define SWSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/swsp_pkg.sv
// Shared types, constants and codes of the sweep waveform segment plotter
`timescale 1ns / 1ps
`default_nettype none
package swsp_pkg;

    localparam int CHANNELS      = 4;
    localparam int COORD_BITS    = 10;
    localparam int SAMPLE_FIELDS = 4;
    localparam int LIVE_CHANNELS = (CHANNELS < SAMPLE_FIELDS) ? CHANNELS : SAMPLE_FIELDS;
    localparam int CH_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_BITS   = 16;
    localparam int DIM_BITS      = 10;
    localparam int POS_BITS      = 10;
    localparam int CHAN_OUT_BITS = 2;
    localparam int ENABLE_BITS   = 4;
    localparam int PROD_BITS     = SAMPLE_BITS + DIM_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIM_BITS);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PLOT_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PLOT_HEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_MIN      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_MAX      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_ENABLE = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AUTO_CLEAR     = 3'd7;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [1:0] KIND_SEGMENT = 2'd0;
    localparam logic [1:0] KIND_CLEAR   = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [DIM_BITS-1:0]    origin_x;
        logic [DIM_BITS-1:0]    origin_y;
        logic [DIM_BITS-1:0]    plot_width;
        logic [DIM_BITS-1:0]    plot_height;
        logic [SAMPLE_BITS-1:0] value_min;
        logic [SAMPLE_BITS-1:0] value_max;
        logic [ENABLE_BITS-1:0] channel_enable;
        logic                   auto_clear;
    } cfg_t;

    // one queued request, already checked against the value window
    typedef struct packed {
        logic                                 op;
        logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample;
        logic [CHANNELS-1:0]                  bad;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [1:0]               status;
        logic [CHAN_OUT_BITS-1:0] channel;
        logic [POS_BITS-1:0]      start_x;
        logic [POS_BITS-1:0]      start_y;
        logic [POS_BITS-1:0]      end_x;
        logic [POS_BITS-1:0]      end_y;
        logic                     last;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/swsp_front.sv
// Front end: takes requests, flags out-of-window samples, queues them
`timescale 1ns / 1ps
`default_nettype none
module swsp_front
    import swsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic                   op,
    input  logic [SAMPLE_BITS-1:0] sample_a,
    input  logic [SAMPLE_BITS-1:0] sample_b,
    input  logic [SAMPLE_BITS-1:0] sample_c,
    input  logic [SAMPLE_BITS-1:0] sample_d,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  logic                   cmd_pop
);

    cmd_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    cmd_t                 entry;
    logic                 push;

    generate
        for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
            if (g == 0) begin : g_a
                assign entry.sample[g] = sample_a;
            end
            else if (g == 1) begin : g_b
                assign entry.sample[g] = sample_b;
            end
            else if (g == 2) begin : g_c
                assign entry.sample[g] = sample_c;
            end
            else if (g == 3) begin : g_d
                assign entry.sample[g] = sample_d;
            end
            else begin : g_none
                assign entry.sample[g] = '0;
            end
            // inverted window flags every sample
            assign entry.bad[g] = (entry.sample[g] < cfg.value_min) ||
                                  (entry.sample[g] > cfg.value_max);
        end
    endgenerate

    assign entry.op = op;

    assign sample_stall = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign push         = sample_valid && !sample_stall;
    assign cmd_valid    = (count_reg != '0);
    assign cmd          = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

>>> rtl/swsp_back.sv
// Back end: sweep state, per-channel scaling with a serial divider, result register
`timescale 1ns / 1ps
`default_nettype none
module swsp_back
    import swsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output result_t result,
    output logic    result_valid,
    input  logic    result_stall
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_SEG    = 3'd6;
    localparam logic [2:0] ST_STATUS = 3'd7;

    logic [2:0]              state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic                    draw_reg, draw_next;
    logic [1:0]              status_reg, status_next;
    logic [CH_BITS-1:0]      ch_reg, ch_next;
    logic [DIM_BITS-1:0]     col_reg, col_next;
    logic [COORD_BITS-1:0]   prev_col_reg, prev_col_next;
    logic [COORD_BITS-1:0]   prev_row_reg [CHANNELS];
    logic [COORD_BITS-1:0]   prev_row_next [CHANNELS];
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]  rem_reg, rem_next;
    logic [DIM_BITS-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    result_t                 out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [CHANNELS-1:0]     en_ext;
    logic [SAMPLE_BITS-1:0]  range;
    logic [SAMPLE_BITS-1:0]  diff;
    logic [SAMPLE_BITS:0]    trial;
    logic                    trial_ge;
    logic [DIM_BITS-1:0]     off;
    logic [COORD_BITS-1:0]   row;
    logic [COORD_BITS-1:0]   x_coord;
    logic [COORD_BITS-1:0]   corner_x;
    logic [COORD_BITS-1:0]   corner_y;
    logic                    out_free;
    logic                    last_ch;

    generate
        for (genvar g = 0; g < CHANNELS; g++) begin : g_en
            if (g < ENABLE_BITS) begin : g_live
                assign en_ext[g] = cfg.channel_enable[g];
            end
            else begin : g_dead
                assign en_ext[g] = 1'b0;
            end
        end
    endgenerate

    assign range    = cfg.value_max - cfg.value_min;
    assign diff     = cmd_reg.sample[ch_reg] - cfg.value_min;
    assign trial    = {rem_reg, quo_reg[DIM_BITS-1]};
    assign trial_ge = (trial >= {1'b0, range});
    // empty window gives no offset
    assign off      = (range == '0) ? '0 : quo_reg;
    assign row      = COORD_BITS'(cfg.origin_y) + COORD_BITS'(cfg.plot_height)
                    - COORD_BITS'(off);
    assign x_coord  = COORD_BITS'(cfg.origin_x) + COORD_BITS'(col_reg);
    assign corner_x = COORD_BITS'(cfg.origin_x) + COORD_BITS'(cfg.plot_width);
    assign corner_y = COORD_BITS'(cfg.origin_y) + COORD_BITS'(cfg.plot_height);
    assign out_free = !out_valid_reg || !result_stall;
    assign last_ch  = (ch_reg == CH_BITS'(LIVE_CHANNELS - 1));

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        draw_next      = draw_reg;
        status_next    = status_reg;
        ch_next        = ch_reg;
        col_next       = col_reg;
        prev_col_next  = prev_col_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd_pop        = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            prev_row_next[i] = prev_row_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd;
                    status_next = STATUS_OK;
                    ch_next     = '0;
                    if (cmd.op == OP_CLEAR)
                    begin
                        draw_next  = 1'b0;
                        state_next = ST_CLEAR;
                    end
                    else if (col_reg >= cfg.plot_width && !cfg.auto_clear)
                    begin
                        // sample dropped, sweep restarts
                        col_next      = '0;
                        prev_col_next = COORD_BITS'(cfg.origin_x);
                        status_next   = STATUS_FULL;
                        state_next    = ST_STATUS;
                    end
                    else if (col_reg >= cfg.plot_width)
                    begin
                        draw_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_CLEAR:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.kind    = KIND_CLEAR;
                    out_next.status  = STATUS_OK;
                    out_next.channel = '0;
                    out_next.start_x = cfg.origin_x;
                    out_next.start_y = cfg.origin_y;
                    out_next.end_x   = POS_BITS'(corner_x);
                    out_next.end_y   = POS_BITS'(corner_y);
                    out_next.last    = 1'b0;
                    col_next         = '0;
                    prev_col_next    = COORD_BITS'(cfg.origin_x);
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        prev_row_next[i] = '0;
                    end
                    state_next = draw_reg ? ST_SCAN : ST_STATUS;
                end
            end

            ST_SCAN:
            begin
                if (!en_ext[ch_reg])
                begin
                    if (last_ch)
                    begin
                        prev_col_next = x_coord;
                        col_next      = col_reg + DIM_BITS'(1);
                        state_next    = ST_STATUS;
                    end
                    else
                    begin
                        ch_next = ch_reg + CH_BITS'(1);
                    end
                end
                else if (cmd_reg.bad[ch_reg])
                begin
                    // earlier channels stay drawn, column holds
                    status_next = STATUS_RANGE;
                    state_next  = ST_STATUS;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next  = PROD_BITS'(diff) * PROD_BITS'(cfg.plot_height);
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                // dividend < 2^DIM_BITS * range, so the top part starts below range
                {rem_next, quo_next} = prod_reg + PROD_BITS'(range >> 1);
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (trial_ge)
                begin
                    rem_next = SAMPLE_BITS'(trial - {1'b0, range});
                end
                else
                begin
                    rem_next = trial[SAMPLE_BITS-1:0];
                end
                quo_next = {quo_reg[DIM_BITS-2:0], trial_ge};
                cnt_next = cnt_reg + DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(DIM_BITS - 1))
                begin
                    state_next = ST_SEG;
                end
            end

            ST_SEG:
            begin
                if (col_reg == '0 || out_free)
                begin
                    if (col_reg != '0)
                    begin
                        out_valid_next   = 1'b1;
                        out_next.kind    = KIND_SEGMENT;
                        out_next.status  = STATUS_OK;
                        out_next.channel = CHAN_OUT_BITS'(ch_reg);
                        out_next.start_x = POS_BITS'(x_coord);
                        out_next.start_y = POS_BITS'(row);
                        out_next.end_x   = POS_BITS'(prev_col_reg);
                        out_next.end_y   = POS_BITS'(prev_row_reg[ch_reg]);
                        out_next.last    = 1'b0;
                    end
                    prev_row_next[ch_reg] = row;
                    if (last_ch)
                    begin
                        prev_col_next = x_coord;
                        col_next      = col_reg + DIM_BITS'(1);
                        state_next    = ST_STATUS;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_BITS'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.kind    = KIND_STATUS;
                    out_next.status  = status_reg;
                    out_next.channel = '0;
                    out_next.start_x = '0;
                    out_next.start_y = '0;
                    out_next.end_x   = '0;
                    out_next.end_y   = '0;
                    out_next.last    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            draw_reg      <= 1'b0;
            status_reg    <= STATUS_OK;
            ch_reg        <= '0;
            col_reg       <= '0;
            prev_col_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_row_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            draw_reg      <= draw_next;
            status_reg    <= status_next;
            ch_reg        <= ch_next;
            col_reg       <= col_next;
            prev_col_reg  <= prev_col_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_row_reg[i] <= prev_row_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire

>>> rtl/sweep_waveform_segment_plotter.sv
// Top level of the sweep waveform segment plotter: register file, front and back ends
//
//  channel   direction  handshake                      payload
//  sample    in         sample_valid / sample_stall    op, sample_a .. sample_d
//  result    out        result_valid / result_stall    kind, status, channel, start/end x/y, last
//  config    in         cfg_write (no wait)            cfg_index, cfg_data
//
// One request at a time in the back end. Each enabled channel takes a window check, a multiply,
// a load, 10 restoring divide steps and a row; a disabled channel is only skipped, and an
// out-of-window sample ends the scan at its channel.
// The serial divider is shared by all channels; a two-entry queue lets the next request in.
// Reset clears sweep state and registers (auto_clear comes up set); no memory sweep.
// A stalled result holds the back end only when it has another result to deliver.
`timescale 1ns / 1ps
`default_nettype none
module sweep_waveform_segment_plotter
    import swsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic                      op,
    input  logic [SAMPLE_BITS-1:0]    sample_a,
    input  logic [SAMPLE_BITS-1:0]    sample_b,
    input  logic [SAMPLE_BITS-1:0]    sample_c,
    input  logic [SAMPLE_BITS-1:0]    sample_d,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [1:0]                kind,
    output logic [1:0]                status,
    output logic [CHAN_OUT_BITS-1:0]  channel,
    output logic [POS_BITS-1:0]       start_x,
    output logic [POS_BITS-1:0]       start_y,
    output logic [POS_BITS-1:0]       end_x,
    output logic [POS_BITS-1:0]       end_y,
    output logic                      last
);

    cfg_t    cfg_reg, cfg_next;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:       cfg_next.origin_x       = cfg_data[DIM_BITS-1:0];
                REG_ORIGIN_Y:       cfg_next.origin_y       = cfg_data[DIM_BITS-1:0];
                REG_PLOT_WIDTH:     cfg_next.plot_width     = cfg_data[DIM_BITS-1:0];
                REG_PLOT_HEIGHT:    cfg_next.plot_height    = cfg_data[DIM_BITS-1:0];
                REG_VALUE_MIN:      cfg_next.value_min      = cfg_data[SAMPLE_BITS-1:0];
                REG_VALUE_MAX:      cfg_next.value_max      = cfg_data[SAMPLE_BITS-1:0];
                REG_CHANNEL_ENABLE: cfg_next.channel_enable = cfg_data[ENABLE_BITS-1:0];
                REG_AUTO_CLEAR:     cfg_next.auto_clear     = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cfg_t'{auto_clear: 1'b1, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    swsp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .op           (op),
        .sample_a     (sample_a),
        .sample_b     (sample_b),
        .sample_c     (sample_c),
        .sample_d     (sample_d),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    swsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    assign kind    = result.kind;
    assign status  = result.status;
    assign channel = result.channel;
    assign start_x = result.start_x;
    assign start_y = result.start_y;
    assign end_x   = result.end_x;
    assign end_y   = result.end_y;
    assign last    = result.last;

endmodule
`default_nettype wire

>>> rtl/swsp_checker.sv
// Port-level checker for the sweep waveform segment plotter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sweep_waveform_segment_plotter_assert.svh"
module swsp_checker
    import swsp_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      result_valid,
    input logic                      result_stall,
    input logic [1:0]                kind,
    input logic [1:0]                status,
    input logic [CHAN_OUT_BITS-1:0]  channel,
    input logic [POS_BITS-1:0]       start_x,
    input logic [POS_BITS-1:0]       start_y,
    input logic [POS_BITS-1:0]       end_x,
    input logic [POS_BITS-1:0]       end_y,
    input logic                      last
);

    logic [2*2+CHAN_OUT_BITS+4*POS_BITS:0] payload;
    logic                                  held;
    logic                                  is_status;
    logic                                  status_out;
    logic                                  draw_out;
    logic                                  coord_any;

    assign payload    = {kind, status, channel, start_x, start_y, end_x, end_y, last};
    assign held       = result_valid && result_stall;
    assign is_status  = (kind == KIND_STATUS);
    assign status_out = result_valid && is_status;
    assign draw_out   = result_valid && !is_status;
    assign coord_any  = |{channel, start_x, start_y, end_x, end_y};

    `SWSP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !result_valid, "result valid during reset")

    `SWSP_ASSERT(a_stall_hold, held |=> result_valid && $stable(payload), "stalled result changed")

    // exactly the status closes a request
    `SWSP_ASSERT(a_last_is_status, result_valid |-> (is_status == last), "last flag not on status")

    `SWSP_ASSERT(a_status_clean, status_out |-> !coord_any, "status carries coordinates")

    `SWSP_ASSERT(a_draw_status_ok, draw_out |-> status == STATUS_OK, "drawing result with status")

endmodule

bind sweep_waveform_segment_plotter swsp_checker u_swsp_checker (.*);
`default_nettype wire

>>> bench/swsp_draw_checker.sv
// Draw-command checker for the sweep plotter: predicts and compares every result
`timescale 1ns / 1ps
module swsp_draw_checker
    import swsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      sample_valid,
    input  logic                      sample_stall,
    input  logic                      op,
    input  logic [SAMPLE_BITS-1:0]    sample_a,
    input  logic [SAMPLE_BITS-1:0]    sample_b,
    input  logic [SAMPLE_BITS-1:0]    sample_c,
    input  logic [SAMPLE_BITS-1:0]    sample_d,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  logic [1:0]                kind,
    input  logic [1:0]                status,
    input  logic [CHAN_OUT_BITS-1:0]  channel,
    input  logic [POS_BITS-1:0]       start_x,
    input  logic [POS_BITS-1:0]       start_y,
    input  logic [POS_BITS-1:0]       end_x,
    input  logic [POS_BITS-1:0]       end_y,
    input  logic                      last,
    output int                        outstanding,
    output int                        mismatches
);

    cfg_t                regs;
    logic [POS_BITS-1:0] sweep_col;
    logic [POS_BITS-1:0] last_x;
    logic [POS_BITS-1:0] last_y [SAMPLE_FIELDS];
    result_t             expected_draws [$];

    initial begin
        outstanding = 0;
        mismatches  = 0;
    end

    function automatic logic [POS_BITS-1:0] row_of(input logic [SAMPLE_BITS-1:0] v);
        logic [31:0] span;
        logic [31:0] offset;
        logic [31:0] row;
        span   = {16'd0, regs.value_max} - {16'd0, regs.value_min};
        offset = 32'd0;
        if (span != 0 && regs.plot_height != 0)
            offset = (({16'd0, v} - {16'd0, regs.value_min}) * {22'd0, regs.plot_height}
                      + (span >> 1)) / span;
        row = {22'd0, regs.origin_y} + {22'd0, regs.plot_height} - offset;
        return row[POS_BITS-1:0];
    endfunction

    task automatic push_draw(input logic [1:0] k, input logic [1:0] st, input int ch,
                             input logic [POS_BITS-1:0] sx, input logic [POS_BITS-1:0] sy,
                             input logic [POS_BITS-1:0] ex, input logic [POS_BITS-1:0] ey,
                             input logic lst);
        result_t r;
        r.kind    = k;
        r.status  = st;
        r.channel = ch[CHAN_OUT_BITS-1:0];
        r.start_x = sx;
        r.start_y = sy;
        r.end_x   = ex;
        r.end_y   = ey;
        r.last    = lst;
        expected_draws.push_back(r);
    endtask

    task automatic clear_sweep();
        logic [POS_BITS-1:0] right;
        logic [POS_BITS-1:0] bottom;
        right  = regs.origin_x + regs.plot_width;
        bottom = regs.origin_y + regs.plot_height;
        push_draw(KIND_CLEAR, STATUS_OK, 0, regs.origin_x, regs.origin_y, right, bottom, 1'b0);
        sweep_col = '0;
        last_x    = regs.origin_x;
        for (int i = 0; i < SAMPLE_FIELDS; i++)
            last_y[i] = '0;
    endtask

    task automatic predict_draws(input logic req_op,
                                 input logic [SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] vals);
        logic [1:0]          st;
        logic [POS_BITS-1:0] x;
        logic [POS_BITS-1:0] y;
        st = STATUS_OK;
        if (req_op == OP_CLEAR) begin
            clear_sweep();
        end else if (sweep_col >= regs.plot_width && !regs.auto_clear) begin
            // full sweep: restart, drop the sample, rows kept
            sweep_col = '0;
            last_x    = regs.origin_x;
            st        = STATUS_FULL;
        end else begin
            if (sweep_col >= regs.plot_width)
                clear_sweep();
            x = regs.origin_x + sweep_col;
            for (int ch = 0; ch < SAMPLE_FIELDS && st == STATUS_OK; ch++) begin
                if (regs.channel_enable[ch]) begin
                    if (vals[ch] < regs.value_min || vals[ch] > regs.value_max) begin
                        st = STATUS_RANGE;
                    end else begin
                        y = row_of(vals[ch]);
                        if (sweep_col != 0)
                            push_draw(KIND_SEGMENT, STATUS_OK, ch, x, y, last_x, last_y[ch],
                                      1'b0);
                        last_y[ch] = y;
                    end
                end
            end
            if (st == STATUS_OK) begin
                last_x    = x;
                sweep_col = sweep_col + POS_BITS'(1);
            end
        end
        push_draw(KIND_STATUS, st, 0, '0, '0, '0, '0, 1'b1);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            regs            = '0;
            regs.auto_clear = 1'b1;
            sweep_col       = '0;
            last_x          = '0;
            for (int i = 0; i < SAMPLE_FIELDS; i++)
                last_y[i] = '0;
            expected_draws.delete();
            outstanding = 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_ORIGIN_X:       regs.origin_x       = cfg_data[DIM_BITS-1:0];
                    REG_ORIGIN_Y:       regs.origin_y       = cfg_data[DIM_BITS-1:0];
                    REG_PLOT_WIDTH:     regs.plot_width     = cfg_data[DIM_BITS-1:0];
                    REG_PLOT_HEIGHT:    regs.plot_height    = cfg_data[DIM_BITS-1:0];
                    REG_VALUE_MIN:      regs.value_min      = cfg_data;
                    REG_VALUE_MAX:      regs.value_max      = cfg_data;
                    REG_CHANNEL_ENABLE: regs.channel_enable = cfg_data[ENABLE_BITS-1:0];
                    REG_AUTO_CLEAR:     regs.auto_clear     = cfg_data[0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
                predict_draws(op, {sample_d, sample_c, sample_b, sample_a});
            if (result_valid && !result_stall) begin
                if (expected_draws.size() == 0) begin
                    $error("result with no request pending: kind %0d status %0d", kind, status);
                    mismatches++;
                end else begin
                    want = expected_draws.pop_front();
                    check_field("kind", int'(want.kind), int'(kind));
                    check_field("status", int'(want.status), int'(status));
                    check_field("channel", int'(want.channel), int'(channel));
                    check_field("start_x", int'(want.start_x), int'(start_x));
                    check_field("start_y", int'(want.start_y), int'(start_y));
                    check_field("end_x", int'(want.end_x), int'(end_x));
                    check_field("end_y", int'(want.end_y), int'(end_y));
                    check_field("last", int'(want.last), int'(last));
                end
            end
            outstanding = expected_draws.size();
        end
    end

endmodule

>>> bench/sweep_waveform_segment_plotter_tb.sv
// Testbench top for the sweep plotter: clock, reset, register setup, request traffic, verdict
`timescale 1ns / 1ps
module sweep_waveform_segment_plotter_tb;
    import swsp_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      sample_valid;
    logic                      sample_stall;
    logic                      op;
    logic [SAMPLE_BITS-1:0]    sample_a;
    logic [SAMPLE_BITS-1:0]    sample_b;
    logic [SAMPLE_BITS-1:0]    sample_c;
    logic [SAMPLE_BITS-1:0]    sample_d;
    logic                      result_valid;
    logic                      result_stall;
    logic [1:0]                kind;
    logic [1:0]                status;
    logic [CHAN_OUT_BITS-1:0]  channel;
    logic [POS_BITS-1:0]       start_x;
    logic [POS_BITS-1:0]       start_y;
    logic [POS_BITS-1:0]       end_x;
    logic [POS_BITS-1:0]       end_y;
    logic                      last;

    int   outstanding;
    int   mismatches;
    int   send_gap_pct  = 26;
    int   take_stall_pct = 26;
    int   quiet_cycles  = 0;
    cfg_t plot_cfg;

    sweep_waveform_segment_plotter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .op           (op),
        .sample_a     (sample_a),
        .sample_b     (sample_b),
        .sample_c     (sample_c),
        .sample_d     (sample_d),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .status       (status),
        .channel      (channel),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .last         (last)
    );

    swsp_draw_checker draw_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .op           (op),
        .sample_a     (sample_a),
        .sample_b     (sample_b),
        .sample_c     (sample_c),
        .sample_d     (sample_d),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .status       (status),
        .channel      (channel),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .last         (last),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < take_stall_pct);
    end

    // nothing accepted on either channel for too long means a hang
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic cfg_t make_cfg(input int ox, input int oy, input int w, input int h,
                                      input int lo, input int hi, input int en, input int ac);
        cfg_t r;
        r.origin_x       = ox[DIM_BITS-1:0];
        r.origin_y       = oy[DIM_BITS-1:0];
        r.plot_width     = w[DIM_BITS-1:0];
        r.plot_height    = h[DIM_BITS-1:0];
        r.value_min      = lo[SAMPLE_BITS-1:0];
        r.value_max      = hi[SAMPLE_BITS-1:0];
        r.channel_enable = en[ENABLE_BITS-1:0];
        r.auto_clear     = ac[0];
        return r;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t r;
        int   pick;
        int   a;
        int   b;
        r.origin_x    = DIM_BITS'($urandom_range(1023));
        r.origin_y    = DIM_BITS'($urandom_range(1023));
        r.plot_height = DIM_BITS'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 5)
            r.plot_width = '0;
        else if (pick < 85)
            r.plot_width = DIM_BITS'($urandom_range(24, 1));
        else
            r.plot_width = DIM_BITS'($urandom_range(1023, 25));
        a    = $urandom_range(65535);
        b    = $urandom_range(65535);
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            // inverted window
            r.value_min = SAMPLE_BITS'((a > b) ? a : b);
            r.value_max = SAMPLE_BITS'((a > b) ? b : a);
        end
        else if (pick < 13)
        begin
            r.value_min = SAMPLE_BITS'(a);
            r.value_max = SAMPLE_BITS'(a);
        end
        else if (pick < 40)
        begin
            r.value_min = SAMPLE_BITS'($urandom_range(65000));
            r.value_max = SAMPLE_BITS'(r.value_min + $urandom_range(500));
        end
        else
        begin
            r.value_min = SAMPLE_BITS'((a < b) ? a : b);
            r.value_max = SAMPLE_BITS'((a < b) ? b : a);
        end
        r.channel_enable = ($urandom_range(99) < 10) ? '0
                         : ENABLE_BITS'($urandom_range(15, 1));
        r.auto_clear     = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_value(input cfg_t r);
        int pick;
        pick = $urandom_range(99);
        if (r.value_min > r.value_max || pick < 8)
            return SAMPLE_BITS'($urandom_range(65535));
        if (pick < 12)
            return (pick < 10) ? r.value_min : r.value_max;
        return SAMPLE_BITS'(r.value_min + $urandom_range(r.value_max - r.value_min));
    endfunction

    task automatic send_request(input logic req_op,
                                input logic [SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] vals);
        while ($urandom_range(99) < send_gap_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        op           <= req_op;
        sample_a     <= vals[0];
        sample_b     <= vals[1];
        sample_c     <= vals[2];
        sample_d     <= vals[3];
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    task automatic send_samples(input int a, input int b, input int c, input int d);
        send_request(OP_SAMPLE, {d[15:0], c[15:0], b[15:0], a[15:0]});
    endtask

    // hold off new requests until every expected result is back
    task automatic drain();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic load_cfg(input cfg_t r);
        drain();
        put_reg(REG_ORIGIN_X, int'(r.origin_x));
        put_reg(REG_ORIGIN_Y, int'(r.origin_y));
        put_reg(REG_PLOT_WIDTH, int'(r.plot_width));
        put_reg(REG_PLOT_HEIGHT, int'(r.plot_height));
        put_reg(REG_VALUE_MIN, int'(r.value_min));
        put_reg(REG_VALUE_MAX, int'(r.value_max));
        put_reg(REG_CHANNEL_ENABLE, int'(r.channel_enable));
        put_reg(REG_AUTO_CLEAR, int'(r.auto_clear));
        cfg_write <= 1'b0;
        plot_cfg = r;
    endtask

    initial
    begin
        logic [SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] vals;
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        sample_valid <= 1'b0;
        op           <= OP_SAMPLE;
        sample_a     <= '0;
        sample_b     <= '0;
        sample_c     <= '0;
        sample_d     <= '0;
        result_stall <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // plain sweep: segments, window edges, out-of-range stop, wrap with auto-clear
        load_cfg(make_cfg(100, 50, 4, 200, 1000, 5000, 4'hF, 1));
        send_samples(1000, 5000, 3000, 2000);
        send_samples(5000, 1000, 1001, 4999);
        send_samples(2000, 3000, 5001, 2500);
        send_samples(999, 3000, 3000, 3000);
        send_samples(1500, 1500, 1500, 1500);
        send_samples(4000, 2000, 1200, 4800);
        send_samples(3333, 4444, 1111, 2222);
        send_samples(2500, 2500, 2600, 2700);
        send_request(OP_CLEAR, '0);

        // full sweep reported, partial channel set
        load_cfg(make_cfg(10, 20, 2, 100, 0, 1000, 4'b1010, 0));
        send_samples(0, 0, 0, 1000);
        send_samples(0, 500, 0, 250);
        send_samples(0, 700, 0, 300);
        send_samples(0, 900, 0, 100);
        send_samples(0, 100, 0, 900);

        // largest coordinates and full sample span, wrapping screen math
        load_cfg(make_cfg(1023, 1023, 1023, 1023, 0, 65535, 4'hF, 1));
        send_samples(0, 65535, 32768, 1);
        send_samples(65535, 0, 32767, 65534);

        // inverted window
        load_cfg(make_cfg(5, 6, 5, 300, 5000, 1000, 4'b0110, 1));
        send_samples(3000, 3000, 3000, 3000);
        // empty window
        load_cfg(make_cfg(300, 400, 5, 300, 777, 777, 4'hF, 1));
        send_samples(777, 777, 777, 777);
        send_samples(777, 777, 777, 777);
        // zero height
        load_cfg(make_cfg(0, 900, 5, 0, 0, 100, 4'hF, 1));
        send_samples(50, 0, 100, 7);
        send_samples(20, 30, 40, 60);
        // no channel enabled: column still moves until full
        load_cfg(make_cfg(40, 40, 2, 40, 0, 10, 4'h0, 0));
        send_samples(1, 2, 3, 4);
        send_samples(1, 2, 3, 4);
        send_samples(1, 2, 3, 4);
        // zero width with auto-clear: every sample clears first
        load_cfg(make_cfg(700, 10, 0, 50, 100, 200, 4'b0011, 1));
        send_samples(150, 200, 0, 0);
        send_samples(100, 120, 0, 0);

        for (int phase = 0; phase < 8; phase++)
        begin
            load_cfg(random_cfg());
            send_gap_pct   = (phase == 2) ? 0 : 26;
            take_stall_pct = (phase == 2) ? 0 : 26;
            for (int n = 0; n < 48; n++)
            begin
                if ($urandom_range(49) == 0)
                    drain();
                for (int ch = 0; ch < SAMPLE_FIELDS; ch++)
                    vals[ch] = pick_value(plot_cfg);
                send_request(($urandom_range(99) < 4) ? OP_CLEAR : OP_SAMPLE, vals);
            end
        end

        drain();
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/swsp_pkg.sv
rtl/swsp_front.sv
rtl/swsp_back.sv
rtl/sweep_waveform_segment_plotter.sv
rtl/swsp_checker.sv
bench/swsp_draw_checker.sv
bench/sweep_waveform_segment_plotter_tb.sv
